FILE: src/tss_pkg.sv
// Shared types and constants of the triangular system solver.
package tss_pkg;

  // Input opcodes
  localparam logic [1:0] OP_WR_COEF = 2'd0;
  localparam logic [1:0] OP_WR_RHS  = 2'd1;
  localparam logic [1:0] OP_SOLVE   = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_ACTIVE_SIZE = 1'd0;
  localparam logic [0:0] REG_SNAP        = 1'd1;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 4;
  localparam int CFG_W  = 31;

  // Classified command passed from the front end to the solve engine
  typedef struct packed {
    logic [1:0]        op;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              forward;
  } cmd_t;

  // One finished result
  typedef struct packed {
    logic [ROW_W-1:0]  index;
    logic [DATA_W-1:0] solution;
    logic              last;
    logic              zero_pivot;
  } res_t;

endpackage

FILE: src/tss_cmd_queue.sv
// Short command queue between the front end and the solve engine.
module tss_cmd_queue import tss_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);
  localparam int AW = $clog2(DEPTH);

  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + AW'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + (AW+1)'(1);
        2'b01:   count_r <= count_r - (AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end
endmodule

FILE: src/tss_divider.sv
// Restoring signed divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module tss_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] quotient
);
  logic [63:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] dvs_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted  = {rem_r[31:0], quo_r[63]};
  assign trial    = shifted - {1'b0, dvs_r};
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  // Iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        quo_r  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        dvs_r  <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg_r  <= dividend[63] ^ divisor[31];
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial;
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/tss_engine.sv
// Solve engine: holds the stores and runs substitution one row at a time.
module tss_engine import tss_pkg::*; #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [4:0]        active_size,
  input  logic [CFG_W-1:0]  snap_threshold,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_ready
);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int CW = $clog2(MAX_SIZE + 1);
  // Row and column are concatenated into the address
  localparam int CDEPTH = 1 << (2 * IW);
  localparam logic signed [63:0] LIM = 64'sd1 <<< (62 - FRAC_BITS);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic signed [31:0] coef_mem [CDEPTH];
  logic signed [31:0] rhs_mem  [MAX_SIZE];
  logic signed [31:0] sol_mem  [MAX_SIZE];

  logic [2:0]         state_r;
  logic [CW-1:0]      n_r, k_r;
  logic [IW-1:0]      i_r, j_r, clr_r;
  logic               fwd_r, jv_r, jlast_r;
  logic [IW-1:0]      jd_r;
  logic signed [31:0] coef_rd_r, sol_rd_r, rhs_rd_r, diag_r;
  logic signed [63:0] prod_r, sum_r, num_r;
  logic               pv_r, zp_r;
  logic signed [31:0] q_r;
  logic               out_v_r;
  res_t               out_r;
  logic               div_start, div_busy, div_done;
  logic signed [63:0] div_q;
  logic [CW-1:0]      n_eff;
  logic signed [63:0] prod_fl, qsat, qabs;
  logic signed [31:0] q_fin;

  tss_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(num_r <<< FRAC_BITS), .divisor(diag_r),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    if (active_size == 5'd0) n_eff = CW'(1);
    else if (32'(active_size) > MAX_SIZE) n_eff = CW'(MAX_SIZE);
    else n_eff = CW'(active_size);
  end

  // Arithmetic shift floors the product
  assign prod_fl = prod_r >>> FRAC_BITS;
  assign qsat = (div_q > 64'sd2147483647) ? 64'sd2147483647 :
                (div_q < -64'sd2147483648) ? -64'sd2147483648 : div_q;
  assign qabs = q_r[31] ? -64'(q_r) : 64'(q_r);
  assign q_fin = (qabs < 64'(snap_threshold)) ? 32'sd0 : q_r;

  // Divider starts on the first wait cycle, once the numerator is clamped
  assign div_start = (state_r == S_WAIT) && !div_busy && !div_done;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid &&
                     (cmd.op != OP_SOLVE || !out_v_r);
  assign res_valid = out_v_r;
  assign res       = out_r;

  // Store writes and row-wise reads
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_WR_COEF && 32'(cmd.row) < MAX_SIZE &&
        32'(cmd.col) < MAX_SIZE)
      coef_mem[{IW'(cmd.row), IW'(cmd.col)}] <= cmd.value;
    if (cmd_pop && cmd.op == OP_WR_RHS && 32'(cmd.row) < MAX_SIZE)
      rhs_mem[IW'(cmd.row)] <= cmd.value;
    coef_rd_r <= coef_mem[{i_r, j_r}];
    sol_rd_r  <= sol_mem[j_r];
    rhs_rd_r  <= rhs_mem[i_r];
    if (state_r == S_CLR) sol_mem[clr_r] <= '0;
    else if (state_r == S_OUT && !out_v_r) sol_mem[i_r] <= q_fin;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      pv_r    <= 1'b0;
      jv_r    <= 1'b0;
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd.op == OP_SOLVE) begin
            n_r     <= n_eff;
            fwd_r   <= cmd.forward;
            clr_r   <= '0;
            k_r     <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + IW'(1);
          if (32'(clr_r) == MAX_SIZE - 1) state_r <= S_ROW;
        end
        S_ROW: begin
          i_r     <= fwd_r ? IW'(k_r) : IW'(n_r - k_r - CW'(1));
          j_r     <= '0;
          sum_r   <= '0;
          jv_r    <= 1'b0;
          pv_r    <= 1'b0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // Read stage, multiply stage, accumulate stage
          jv_r    <= 1'b1;
          jd_r    <= j_r;
          jlast_r <= (CW'(j_r) == n_r - CW'(1));
          if (CW'(j_r) != n_r - CW'(1)) j_r <= j_r + IW'(1);
          if (jv_r) begin
            if (jd_r == i_r) begin
              diag_r <= coef_rd_r;
              prod_r <= '0;
            end else prod_r <= 64'(coef_rd_r) * 64'(sol_rd_r);
            pv_r <= 1'b1;
            if (jlast_r) state_r <= S_ACC;
          end
          if (pv_r) sum_r <= sum_r + prod_fl;
        end
        S_ACC: begin
          sum_r   <= sum_r + prod_fl;
          pv_r    <= 1'b0;
          state_r <= S_DIV;
          num_r   <= 64'(rhs_rd_r) - (sum_r + prod_fl);
        end
        S_DIV: begin
          if (num_r > LIM) num_r <= LIM;
          else if (num_r < -LIM) num_r <= -LIM;
          if (diag_r == 0) begin
            q_r <= (num_r > 0) ? 32'sh7fffffff :
                   (num_r < 0) ? 32'sh80000000 : 32'sd0;
            zp_r    <= 1'b1;
            state_r <= S_OUT;
          end else begin
            zp_r    <= 1'b0;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            q_r     <= qsat[31:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v_r) begin
            out_v_r             <= 1'b1;
            out_r.index         <= ROW_W'(i_r);
            out_r.solution      <= q_fin;
            out_r.last          <= (k_r == n_r - CW'(1));
            out_r.zero_pivot    <= zp_r;
            k_r <= k_r + CW'(1);
            state_r <= (k_r == n_r - CW'(1)) ? S_IDLE : S_ROW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/triangular_system_solver.sv
// Top level of the triangular system solver.
// Loads pass through a four-entry command queue. A solve of size n clears
// the solution store, then per row runs one multiply-accumulate a cycle
// over n columns, a one-bit-a-cycle divider (skipped on a zero diagonal)
// and posts the result. Results wait in one output register; the next
// row's result is held until it is taken. Loads queued behind a solve run
// after it.
module triangular_system_solver import tss_pkg::*; #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               in_opcode,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [ROW_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_forward,
  output logic                     empty,
  input  logic                     pop,
  output logic [ROW_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_solution,
  output logic                     out_last,
  output logic                     out_zero_pivot,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);
  logic [4:0]       active_size_r;
  logic [CFG_W-1:0] snap_r;
  cmd_t             in_cmd, q_cmd;
  logic             q_empty, q_pop, res_valid;
  res_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= 5'd16;
      snap_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_SIZE: active_size_r <= cfg_data[4:0];
        REG_SNAP:        snap_r        <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Front end: pack and queue the item
  assign in_cmd = '{op: in_opcode, row: in_row, col: in_col,
                    value: in_value, forward: in_forward};

  tss_cmd_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(in_cmd), .full(full),
    .pop(q_pop), .pop_cmd(q_cmd), .empty(q_empty)
  );

  tss_engine #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd),
    .cmd_pop(q_pop), .active_size(active_size_r), .snap_threshold(snap_r),
    .res_valid(res_valid), .res(res), .res_ready(pop)
  );

  assign empty          = !res_valid;
  assign out_index      = res.index;
  assign out_solution   = res.solution;
  assign out_last       = res.last;
  assign out_zero_pivot = res.zero_pivot;
endmodule
